// File: sv/vactrol_envelope_generator_unit_macros.svh
// Assertion macros for the vactrol envelope generator unit.
`ifndef VACTROL_ENVELOPE_GENERATOR_UNIT_MACROS_SVH
`define VACTROL_ENVELOPE_GENERATOR_UNIT_MACROS_SVH

`ifndef SYNTH

`define VEG_ASSERT_SAME(name, clk_s, rstn_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("envelope generator check failed");

`define VEG_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("envelope generator check failed");

`else

`define VEG_ASSERT_SAME(name, clk_s, rstn_s, ante, cons)

`define VEG_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons)

`endif

`endif

// File: sv/veg_pkg.sv
// Package: widths, codes and command types of the vactrol envelope generator.
package veg_pkg;

	localparam int LEVEL_FRAC_BITS = 16;
	localparam int RATE_FRAC_BITS  = 24;

	localparam int LVL_W    = LEVEL_FRAC_BITS + 1;
	localparam int RATE_W   = RATE_FRAC_BITS;
	localparam int MUL_A_W  = (RATE_W > LVL_W) ? RATE_W : LVL_W;
	localparam int PROD_W   = MUL_A_W + LVL_W;
	localparam int KSUM_W   = PROD_W - LEVEL_FRAC_BITS + 2;
	localparam int FLOOR_W  = LEVEL_FRAC_BITS;
	localparam int CFG_W    = MUL_A_W;

	localparam logic [LVL_W-1:0]   LVL_ONE     = LVL_W'(1) << LEVEL_FRAC_BITS;
	localparam logic [RATE_W-1:0]  RATE_HALF   = RATE_W'(1) << (RATE_FRAC_BITS - 1);
	localparam logic [RATE_W-1:0]  RATE_CAP    =
		RATE_W'((64'd1 << RATE_FRAC_BITS) / 64'd5);
	localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(82);

	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_SET     = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam logic [1:0] MODE_ONESHOT = 2'd0;
	localparam logic [1:0] MODE_SUSTAIN = 2'd1;
	localparam logic [1:0] MODE_CYCLE   = 2'd2;

	localparam logic [1:0] REG_ENV_MODE    = 2'd0;
	localparam logic [1:0] REG_RISE_RATE   = 2'd1;
	localparam logic [1:0] REG_FALL_RATE   = 2'd2;
	localparam logic [1:0] REG_NOISE_FLOOR = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_KR,
		ST_KCALC,
		ST_COMMIT
	} veg_state_t;

	typedef enum logic [1:0] {
		MUL_SQ,
		MUL_KR,
		MUL_DK
	} veg_mul_sel_t;

	typedef struct packed {
		logic         latch;
		veg_mul_sel_t mul_sel;
		logic         prod_en;
		logic         k_en;
		logic         commit;
	} veg_cmd_t;

endpackage

// File: sv/veg_ifs.sv
// Channel interfaces: request, response and configuration write.
interface veg_req_if;
	logic                    valid;
	logic                    ready;
	logic [1:0]              op;
	logic [veg_pkg::LVL_W-1:0] target_value;

	modport source (output valid, output op, output target_value, input ready);
	modport sink (input valid, input op, input target_value, output ready);
endinterface

interface veg_rsp_if;
	logic                    valid;
	logic                    ready;
	logic [veg_pkg::LVL_W-1:0] level;

	modport source (output valid, output level, input ready);
	modport sink (input valid, input level, output ready);
endinterface

interface veg_cfg_if;
	logic                    valid;
	logic                    ready;
	logic [1:0]              index;
	logic [veg_pkg::CFG_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/vactrol_envelope_generator_unit.sv
// Top level of the vactrol envelope generator: controller plus datapath.
//
//  channel  role  moves
//  req      sink  op, target_value (one item per transfer)
//  rsp      src   level (one result per item)
//  cfg      sink  index, data (register write, always ready)
//
// A tick runs through steps: level squared, rate times square, coefficient
// clamp, then difference times coefficient; one shared multiplier forms the products.
// Set-target, restart and unused ops skip these steps and go straight to commit.
// A new item is accepted while the previous result waits in the output
// register; its commit waits until that register is free.
// Reset: asynchronous, active low; no clearing pass.
`include "vactrol_envelope_generator_unit_macros.svh"

module vactrol_envelope_generator_unit (
	input logic     clk,
	input logic     arst_n,
	veg_req_if.sink   req,
	veg_rsp_if.source rsp,
	veg_cfg_if.sink   cfg
);

	veg_pkg::veg_cmd_t cmd;
	logic              in_tick;

	assign cfg.ready = 1'b1;

	veg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_tick   (in_tick),
		.in_ready  (req.ready),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.cmd       (cmd)
	);

	veg_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.in_op           (req.op),
		.in_target_value (req.target_value),
		.in_tick         (in_tick),
		.cfg_we          (cfg.valid),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.out_level       (rsp.level)
	);

	`VEG_ASSERT_SAME(a_commit_out_free, clk, arst_n, cmd.commit, (!rsp.valid || rsp.ready))
	`VEG_ASSERT_NEXT(a_accept_busy, clk, arst_n, (req.valid && req.ready), !req.ready)
	`VEG_ASSERT_NEXT(a_commit_shows, clk, arst_n, cmd.commit, rsp.valid)

endmodule

// File: sv/veg_ctrl.sv
// Controller: sequences the shared multiplier and the commit of each item.
module veg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_tick,
	output logic              in_ready,
	input  logic              out_ready,
	output logic              out_valid,
	output veg_pkg::veg_cmd_t cmd
);

	veg_pkg::veg_state_t state_q, state_n;
	logic                out_valid_q;
	logic                out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= veg_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_n     = state_q;
		in_ready    = 1'b0;
		cmd.latch   = 1'b0;
		cmd.mul_sel = veg_pkg::MUL_SQ;
		cmd.prod_en = 1'b0;
		cmd.k_en    = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			veg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch   = 1'b1;
					cmd.prod_en = 1'b1;
					state_n     = in_tick ? veg_pkg::ST_KR : veg_pkg::ST_COMMIT;
				end
			end
			veg_pkg::ST_KR: begin
				cmd.mul_sel = veg_pkg::MUL_KR;
				cmd.prod_en = 1'b1;
				state_n     = veg_pkg::ST_KCALC;
			end
			veg_pkg::ST_KCALC: begin
				cmd.k_en = 1'b1;
				state_n  = veg_pkg::ST_COMMIT;
			end
			veg_pkg::ST_COMMIT: begin
				cmd.mul_sel = veg_pkg::MUL_DK;
				if (out_free) begin
					cmd.commit = 1'b1;
					state_n    = veg_pkg::ST_IDLE;
				end
			end
			default: state_n = veg_pkg::ST_IDLE;
		endcase
	end

endmodule

// File: sv/veg_datapath.sv
// Datapath: envelope state, configuration registers and the shared multiplier.
module veg_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  veg_pkg::veg_cmd_t           cmd,
	input  logic [1:0]                  in_op,
	input  logic [veg_pkg::LVL_W-1:0]   in_target_value,
	output logic                        in_tick,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [veg_pkg::CFG_W-1:0]   cfg_data,
	output logic [veg_pkg::LVL_W-1:0]   out_level
);

	localparam int LFB    = veg_pkg::LEVEL_FRAC_BITS;
	localparam int RFB    = veg_pkg::RATE_FRAC_BITS;
	localparam int LVL_W  = veg_pkg::LVL_W;
	localparam int RATE_W = veg_pkg::RATE_W;
	localparam int MUL_W  = veg_pkg::MUL_A_W;
	localparam int PROD_W = veg_pkg::PROD_W;
	localparam int KSUM_W = veg_pkg::KSUM_W;

	logic [LVL_W-1:0]            level_q, target_q, velocity_q;
	logic [1:0]                  mode_q;
	logic [RATE_W-1:0]           rise_q, fall_q;
	logic [veg_pkg::FLOOR_W-1:0] floor_q;

	logic [1:0]        op_q;
	logic [LVL_W-1:0]  tv_q;
	logic [PROD_W-1:0] prod_q;
	logic [RATE_W-1:0] k_q;
	logic [LVL_W-1:0]  out_level_q;

	logic              rising, near;
	logic [LVL_W-1:0]  diff, sq, step, tv_sat;
	logic [RATE_W-1:0] rate_sel, k_next;
	logic [KSUM_W-1:0] ksum;
	logic [MUL_W-1:0]  mul_a;
	logic [LVL_W-1:0]  mul_b;
	logic [PROD_W-1:0] mul_p;
	logic [LVL_W-1:0]  level_n, target_n, velocity_n;

	assign in_tick   = (in_op == veg_pkg::OP_TICK);
	assign out_level = out_level_q;

	assign rising   = target_q > level_q;
	assign diff     = rising ? (target_q - level_q) : (level_q - target_q);
	assign near     = diff < LVL_W'(floor_q);
	assign rate_sel = rising ? rise_q : fall_q;
	assign sq       = prod_q[LFB +: LVL_W];
	assign ksum     = KSUM_W'(rate_sel) + KSUM_W'(prod_q[PROD_W-1:LFB-1]);
	assign k_next   = (ksum > KSUM_W'(veg_pkg::RATE_CAP)) ? veg_pkg::RATE_CAP
		: ksum[RATE_W-1:0];
	assign tv_sat   = (tv_q > veg_pkg::LVL_ONE) ? veg_pkg::LVL_ONE : tv_q;

	always_comb begin
		unique case (cmd.mul_sel)
			veg_pkg::MUL_SQ: begin
				mul_a = MUL_W'(level_q);
				mul_b = level_q;
			end
			veg_pkg::MUL_KR: begin
				mul_a = MUL_W'(rate_sel);
				mul_b = sq;
			end
			veg_pkg::MUL_DK: begin
				mul_a = MUL_W'(k_q);
				mul_b = diff;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign step  = mul_p[RFB +: LVL_W];

	always_comb begin
		level_n    = level_q;
		target_n   = target_q;
		velocity_n = velocity_q;
		case (op_q) inside
			veg_pkg::OP_TICK: begin
				if (rising) begin
					level_n = level_q + step;
					if (near && mode_q != veg_pkg::MODE_SUSTAIN)
						target_n = '0;
				end else begin
					level_n = level_q - step;
					if (near && mode_q == veg_pkg::MODE_CYCLE)
						target_n = velocity_q;
				end
			end
			veg_pkg::OP_SET, veg_pkg::OP_RESTART: begin
				target_n = tv_sat;
				if (tv_sat > LVL_W'(floor_q))
					velocity_n = tv_sat;
				if (op_q == veg_pkg::OP_RESTART)
					level_n = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q    <= '0;
			target_q   <= '0;
			velocity_q <= veg_pkg::LVL_ONE;
			mode_q     <= veg_pkg::MODE_SUSTAIN;
			rise_q     <= veg_pkg::RATE_HALF;
			fall_q     <= veg_pkg::RATE_HALF;
			floor_q    <= veg_pkg::FLOOR_RESET;
		end else begin
			if (cmd.commit) begin
				level_q    <= level_n;
				target_q   <= target_n;
				velocity_q <= velocity_n;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					veg_pkg::REG_ENV_MODE: begin
						mode_q <= cfg_data[1:0];
						if (cfg_data[1:0] != veg_pkg::MODE_SUSTAIN)
							target_q <= '0;
					end
					veg_pkg::REG_RISE_RATE:   rise_q  <= cfg_data[RATE_W-1:0];
					veg_pkg::REG_FALL_RATE:   fall_q  <= cfg_data[RATE_W-1:0];
					veg_pkg::REG_NOISE_FLOOR: floor_q <= cfg_data[veg_pkg::FLOOR_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q <= in_op;
			tv_q <= in_target_value;
		end
		if (cmd.prod_en)
			prod_q <= mul_p;
		if (cmd.k_en)
			k_q <= k_next;
		if (cmd.commit)
			out_level_q <= level_n;
	end

endmodule

// File: tb/vactrol_level_checker.sv
// Scoreboard for the vactrol envelope generator: predicts each level and checks every response.
module vactrol_level_checker (
	input  logic        clk,
	input  logic        arst_n,
	veg_req_if          req,
	veg_rsp_if          rsp,
	veg_cfg_if          cfg,
	output int unsigned fail_count,
	output int unsigned pending
);

	logic [1:0]                  env_mode;
	logic [veg_pkg::RATE_W-1:0]  rise_rate;
	logic [veg_pkg::RATE_W-1:0]  fall_rate;
	logic [veg_pkg::FLOOR_W-1:0] noise_floor;
	logic [veg_pkg::LVL_W-1:0]   level_now;
	logic [veg_pkg::LVL_W-1:0]   level_goal;
	logic [veg_pkg::LVL_W-1:0]   velocity;
	logic [veg_pkg::LVL_W-1:0]   expected_levels[$];
	int unsigned                 errors;

	// min(r + 2*r*level^2, 0.2), truncated like the datapath
	function automatic logic [63:0] slew_gain(input logic [veg_pkg::RATE_W-1:0] r,
			input logic [veg_pkg::LVL_W-1:0] lvl);
		logic [63:0] sq;
		logic [63:0] k;
		sq = (64'(lvl) * 64'(lvl)) >> veg_pkg::LEVEL_FRAC_BITS;
		k = 64'(r) + ((64'(r) * sq * 64'd2) >> veg_pkg::LEVEL_FRAC_BITS);
		return (k > 64'(veg_pkg::RATE_CAP)) ? 64'(veg_pkg::RATE_CAP) : k;
	endfunction

	task automatic write_register(input logic [1:0] idx,
			input logic [veg_pkg::CFG_W-1:0] data);
		case (idx)
		veg_pkg::REG_ENV_MODE: begin
			env_mode = data[1:0];
			if (env_mode != veg_pkg::MODE_SUSTAIN)
				level_goal = '0;
		end
		veg_pkg::REG_RISE_RATE: rise_rate = data[veg_pkg::RATE_W-1:0];
		veg_pkg::REG_FALL_RATE: fall_rate = data[veg_pkg::RATE_W-1:0];
		veg_pkg::REG_NOISE_FLOOR: noise_floor = data[veg_pkg::FLOOR_W-1:0];
		endcase
	endtask

	task automatic step_envelope(input logic [1:0] op,
			input logic [veg_pkg::LVL_W-1:0] tv);
		logic [63:0]               diff;
		logic [63:0]               gain;
		logic [63:0]               delta;
		logic [veg_pkg::LVL_W-1:0] goal;
		case (op)
		veg_pkg::OP_TICK: begin
			if (level_goal > level_now) begin
				diff = 64'(level_goal - level_now);
				gain = slew_gain(rise_rate, level_now);
				delta = (diff * gain) >> veg_pkg::RATE_FRAC_BITS;
				level_now = level_now + veg_pkg::LVL_W'(delta);
				if (diff < 64'(noise_floor) && env_mode != veg_pkg::MODE_SUSTAIN)
					level_goal = '0;
			end else begin
				diff = 64'(level_now - level_goal);
				gain = slew_gain(fall_rate, level_now);
				delta = (diff * gain) >> veg_pkg::RATE_FRAC_BITS;
				level_now = level_now - veg_pkg::LVL_W'(delta);
				if (diff < 64'(noise_floor) && env_mode == veg_pkg::MODE_CYCLE)
					level_goal = velocity;
			end
		end
		veg_pkg::OP_SET, veg_pkg::OP_RESTART: begin
			goal = (tv > veg_pkg::LVL_ONE) ? veg_pkg::LVL_ONE : tv;
			level_goal = goal;
			if (goal > veg_pkg::LVL_W'(noise_floor))
				velocity = goal;
			if (op == veg_pkg::OP_RESTART)
				level_now = '0;
		end
		default: ;
		endcase
		expected_levels.push_back(level_now);
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [veg_pkg::LVL_W-1:0] want;
		if (!arst_n) begin
			env_mode = veg_pkg::MODE_SUSTAIN;
			rise_rate = veg_pkg::RATE_HALF;
			fall_rate = veg_pkg::RATE_HALF;
			noise_floor = veg_pkg::FLOOR_RESET;
			level_now = '0;
			level_goal = '0;
			velocity = veg_pkg::LVL_ONE;
			expected_levels.delete();
			errors = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				write_register(cfg.index, cfg.data);
			if (req.valid && req.ready)
				step_envelope(req.op, req.target_value);
			if (rsp.valid && rsp.ready) begin
				if (expected_levels.size() == 0) begin
					$display("%0t: level transfer with no request pending, got %0d",
						$time, rsp.level);
					errors++;
				end else begin
					want = expected_levels.pop_front();
					if (rsp.level !== want) begin
						$display("%0t: level mismatch, expected %0d, got %0d",
							$time, want, rsp.level);
						errors++;
					end
				end
			end
		end
		fail_count <= errors;
		pending <= expected_levels.size();
	end

endmodule

// File: tb/tb_vactrol_envelope_generator_unit.sv
// Testbench top: drives requests with random gaps and register writes, stalls responses, reports the verdict.
module tb_vactrol_envelope_generator_unit;

	localparam logic [1:0] OP_UNUSED     = 2'd3;
	localparam logic [1:0] MODE_RESERVED = 2'd3;
	localparam int         IDLE_LIMIT    = 5000;
	localparam int         PHASE_ITEMS   = 247;
	localparam int         NUM_PHASES    = 7;

	logic        clk;
	logic        arst_n;
	logic        no_gaps;
	int          stall_left = 0;
	int          idle_cycles = 0;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned n_tick, n_set, n_restart, n_unused, n_writes;

	veg_req_if req();
	veg_rsp_if rsp();
	veg_cfg_if cfg();

	vactrol_envelope_generator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	vactrol_level_checker level_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.cfg        (cfg),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #4 clk = ~clk;

	// mostly short, now and then long
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [veg_pkg::LVL_W-1:0] pick_target();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 20)
			return veg_pkg::LVL_ONE;
		if (r < 30)
			return veg_pkg::LVL_W'($urandom_range(0, 300));
		if (r < 40)
			return veg_pkg::LVL_W'($urandom_range(32'h10001, 32'h1FFFF));
		return veg_pkg::LVL_W'($urandom_range(0, 32'h10000));
	endfunction

	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			rsp.ready <= 1'b1;
			if (!no_gaps && $urandom_range(0, 3) == 0)
				stall_left <= pause_len();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
				(cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_item(input logic [1:0] op_code,
			input logic [veg_pkg::LVL_W-1:0] tv);
		int gap;
		gap = (no_gaps || $urandom_range(0, 99) < 60) ? 0 : pause_len();
		repeat (gap) begin
			@(negedge clk);
			req.valid <= 1'b0;
		end
		@(negedge clk);
		req.valid <= 1'b1;
		req.op <= op_code;
		req.target_value <= tv;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		case (op_code)
		veg_pkg::OP_TICK: n_tick++;
		veg_pkg::OP_SET: n_set++;
		veg_pkg::OP_RESTART: n_restart++;
		default: n_unused++;
		endcase
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [veg_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		n_writes++;
	endtask

	task automatic load_setting(input logic [1:0] mode,
			input logic [veg_pkg::RATE_W-1:0] rise,
			input logic [veg_pkg::RATE_W-1:0] fall,
			input logic [veg_pkg::FLOOR_W-1:0] floor_lvl);
		write_reg(veg_pkg::REG_ENV_MODE, {22'($urandom()), mode});
		write_reg(veg_pkg::REG_RISE_RATE, veg_pkg::CFG_W'(rise));
		write_reg(veg_pkg::REG_FALL_RATE, veg_pkg::CFG_W'(fall));
		write_reg(veg_pkg::REG_NOISE_FLOOR, {8'($urandom()), floor_lvl});
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// stop requests, let every level come back, then a few spare cycles
	task automatic drain();
		@(negedge clk);
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int          n;
		int          run;
		int          r;
		logic [1:0]  op_code;
		clk = 1'b0;
		arst_n = 1'b0;
		no_gaps = 1'b1;
		req.valid = 1'b0;
		req.op = veg_pkg::OP_TICK;
		req.target_value = '0;
		cfg.valid = 1'b0;
		cfg.index = veg_pkg::REG_ENV_MODE;
		cfg.data = '0;
		rsp.ready = 1'b0;
		n_tick = 0;
		n_set = 0;
		n_restart = 0;
		n_unused = 0;
		n_writes = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: sustain, half rates, floor 82
		send_item(veg_pkg::OP_TICK, '0);
		send_item(OP_UNUSED, 17'h1FFFF);
		send_item(veg_pkg::OP_SET, 17'h1FFFF);
		repeat (5) send_item(veg_pkg::OP_TICK, '0);
		send_item(veg_pkg::OP_SET, 17'h0FFFF);
		send_item(veg_pkg::OP_TICK, 17'h1FFFF);
		send_item(veg_pkg::OP_SET, 17'd50);
		repeat (3) send_item(veg_pkg::OP_TICK, '0);
		send_item(veg_pkg::OP_RESTART, veg_pkg::LVL_ONE);
		send_item(veg_pkg::OP_TICK, '0);
		send_item(veg_pkg::OP_RESTART, '0);
		send_item(veg_pkg::OP_TICK, '0);
		send_item(veg_pkg::OP_SET, 17'h15555);
		send_item(veg_pkg::OP_TICK, '0);
		send_item(veg_pkg::OP_SET, 17'h0AAAA);
		repeat (2) send_item(veg_pkg::OP_TICK, 17'h15555);
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
			0: load_setting(veg_pkg::MODE_ONESHOT, 24'hFFFFFF, 24'h400000, 16'd82);
			1: load_setting(veg_pkg::MODE_CYCLE, 24'h200000, 24'h100000, 16'd600);
			2: load_setting(MODE_RESERVED, 24'h180000, 24'hFFFFFF, 16'd1500);
			3: load_setting(veg_pkg::MODE_CYCLE, 24'h008000, 24'h020000, 16'hFFFF);
			4: load_setting(veg_pkg::MODE_SUSTAIN, 24'($urandom()), 24'h000000, 16'd0);
			5: load_setting(veg_pkg::MODE_CYCLE, 24'h000000, 24'($urandom()),
				16'($urandom_range(20, 2000)));
			default: load_setting(2'($urandom_range(0, 3)), 24'($urandom()),
				24'($urandom()), 16'($urandom_range(0, 3000)));
			endcase
			no_gaps = 1'b1;
			n = 0;
			while (n < PHASE_ITEMS) begin
				if (n >= 48)
					no_gaps = 1'b0;
				r = $urandom_range(0, 99);
				if (r < 60)
					op_code = veg_pkg::OP_SET;
				else if (r < 90)
					op_code = veg_pkg::OP_RESTART;
				else if (r < 95)
					op_code = OP_UNUSED;
				else
					op_code = veg_pkg::OP_TICK;
				send_item(op_code, pick_target());
				n++;
				run = $urandom_range(4, 80);
				while (run > 0 && n < PHASE_ITEMS) begin
					send_item(veg_pkg::OP_TICK, veg_pkg::LVL_W'($urandom()));
					run--;
					n++;
				end
			end
			drain();
		end

		$display("Covered %0d items: %0d ticks, %0d target sets, %0d restarts, %0d unused ops",
			n_tick + n_set + n_restart + n_unused, n_tick, n_set, n_restart, n_unused);
		$display("Register settings: reset plus %0d loaded by %0d writes; %0d level errors",
			NUM_PHASES, n_writes, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
